>>> src/pulse_sequence_event_builder_macros.svh
// Assertion macros for the pulse sequence event builder checker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef PULSE_SEQUENCE_EVENT_BUILDER_MACROS_SVH
`define PULSE_SEQUENCE_EVENT_BUILDER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define PSEVB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define PSEVB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/psevb_pkg.sv
// Shared types and codes for the pulse sequence event builder.
// No dependencies; used by the core, the top level and the checker.
package psevb_pkg;

  // Builder command codes
  typedef enum logic [3:0] {
    OP_RESET       = 4'd0,
    OP_SET         = 4'd1,
    OP_CLEAR       = 4'd2,
    OP_TOGGLE      = 4'd3,
    OP_SET_MASK    = 4'd4,
    OP_DELAY       = 4'd5,
    OP_ADC_TRIGGER = 4'd6,
    OP_LOOP_START  = 4'd7,
    OP_LOOP_END    = 4'd8,
    OP_FINALIZE    = 4'd9
  } opcode_t;

  // Finalize report codes
  typedef enum logic [1:0] {
    FS_OK      = 2'd0,
    FS_ERROR   = 2'd1,
    FS_INVALID = 2'd2,
    FS_NONE    = 2'd3
  } final_status_t;

  localparam logic [7:0] ADC_FLAG = 8'h01;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned LOOP_W  = 11;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [3:0]  channel;
    logic [7:0]  new_mask;
    logic [31:0] delay_ticks;
    logic [31:0] repeat_count;
  } cmd_t;

  typedef struct packed {
    logic                event_valid;
    logic [31:0]         event_time;
    logic [MASK_W-1:0]   event_mask;
    logic [7:0]          event_flags;
    logic [INDEX_W-1:0]  event_index;
    logic                error_flag;
    logic [1:0]          final_status;
    logic [31:0]         duration;
    logic [LOOP_W-1:0]   loop_first_index;
    logic [LOOP_W-1:0]   loop_last_index;
    logic [31:0]         loop_repeat_count;
  } res_t;

endpackage

>>> src/psevb_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on nothing; payload widths follow the package types.
interface psevb_cmd_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [3:0]  channel;
  logic [7:0]  new_mask;
  logic [31:0] delay_ticks;
  logic [31:0] repeat_count;

  modport source (output valid, opcode, channel, new_mask, delay_ticks, repeat_count,
                  input ready);
  modport sink (input valid, opcode, channel, new_mask, delay_ticks, repeat_count,
                output ready);
endinterface

interface psevb_res_if;
  logic        valid;
  logic        ready;
  logic        event_valid;
  logic [31:0] event_time;
  logic [7:0]  event_mask;
  logic [7:0]  event_flags;
  logic [9:0]  event_index;
  logic        error_flag;
  logic [1:0]  final_status;
  logic [31:0] duration;
  logic [10:0] loop_first_index;
  logic [10:0] loop_last_index;
  logic [31:0] loop_repeat_count;

  modport source (output valid, event_valid, event_time, event_mask, event_flags,
                  event_index, error_flag, final_status, duration, loop_first_index,
                  loop_last_index, loop_repeat_count,
                  input ready);
  modport sink (input valid, event_valid, event_time, event_mask, event_flags,
                event_index, error_flag, final_status, duration, loop_first_index,
                loop_last_index, loop_repeat_count,
                output ready);
endinterface

>>> src/psevb_core.sv
// Builder state registers and the per-command next-state logic.
// Depends on psevb_pkg; produces one result per accepted command.
module psevb_core #(
  parameter int unsigned CHANNELS   = 8,
  parameter int unsigned MAX_EVENTS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  psevb_pkg::cmd_t   cmd,
  output psevb_pkg::res_t   res
);

  localparam int unsigned CW = $clog2(MAX_EVENTS + 1);
  localparam int unsigned EW = CW + psevb_pkg::LOOP_W;

  // Sequence state
  logic [31:0]  time_r,    time_nxt;
  logic [7:0]   levels_r,  levels_nxt;
  logic         err_r,     err_nxt;
  logic [CW-1:0] count_r,  count_nxt;
  logic [31:0]  longest_r, longest_nxt;
  logic [31:0]  last_r,    last_nxt;
  logic         order_r,   order_nxt;
  logic [CW-1:0] lfirst_r, lfirst_nxt;
  logic [CW-1:0] llast_r,  llast_nxt;
  logic [31:0]  lrep_r,    lrep_nxt;

  // Append request built by the command decode
  logic         want_app;
  logic [7:0]   app_mask;
  logic [7:0]   app_flags;
  logic         app_ok;
  logic         full;
  logic         bad_ch;
  logic [7:0]   ch_bit;
  logic [7:0]   new_lvl;
  logic [CW-1:0] cnt_after;
  logic         ord_after;
  logic         loop_bad;
  logic [1:0]   status;
  logic [EW-1:0] idx_ext;
  logic [EW-1:0] lf_ext;
  logic [EW-1:0] ll_ext;
  psevb_pkg::opcode_t op;

  assign op     = psevb_pkg::opcode_t'(cmd.opcode);
  assign full   = (count_r >= CW'(MAX_EVENTS));
  assign bad_ch = ({1'b0, cmd.channel} >= 5'(CHANNELS));
  assign ch_bit = cmd.channel[3] ? 8'h00 : (8'h01 << cmd.channel[2:0]);

  // Command decode: mask update and append request
  always_comb begin
    want_app  = 1'b0;
    app_mask  = levels_r;
    app_flags = 8'h00;
    new_lvl   = levels_r;
    unique case (cmd.opcode[1:0])
      2'd1:    new_lvl = levels_r | ch_bit;
      2'd2:    new_lvl = levels_r & ~ch_bit;
      default: new_lvl = levels_r ^ ch_bit;
    endcase
    unique case (op)
      psevb_pkg::OP_SET, psevb_pkg::OP_CLEAR: begin
        want_app = !err_r && !bad_ch && (new_lvl != levels_r);
        app_mask = new_lvl;
      end
      psevb_pkg::OP_TOGGLE: begin
        want_app = !err_r && !bad_ch;
        app_mask = new_lvl;
      end
      psevb_pkg::OP_SET_MASK: begin
        want_app = !err_r && (cmd.new_mask != levels_r);
        app_mask = cmd.new_mask;
      end
      psevb_pkg::OP_ADC_TRIGGER: begin
        want_app  = !err_r;
        app_flags = psevb_pkg::ADC_FLAG;
      end
      psevb_pkg::OP_FINALIZE: begin
        want_app = !err_r && (levels_r != 8'h00);
        app_mask = 8'h00;
      end
      default: want_app = 1'b0;
    endcase
  end

  // Append bookkeeping shared by all event-producing commands
  assign app_ok    = want_app && !full;
  assign cnt_after = count_r + CW'(app_ok);
  assign ord_after = order_r && !(app_ok && (count_r != '0) && (time_r < last_r));
  assign loop_bad  = (llast_r != '0) &&
                     ((lfirst_r >= cnt_after) || (llast_r >= cnt_after) ||
                      (lfirst_r > llast_r));

  // Next state and finalize status
  always_comb begin
    time_nxt    = time_r;
    levels_nxt  = levels_r;
    err_nxt     = err_r;
    count_nxt   = cnt_after;
    longest_nxt = (app_ok && (time_r > longest_r)) ? time_r : longest_r;
    last_nxt    = app_ok ? time_r : last_r;
    order_nxt   = ord_after;
    lfirst_nxt  = lfirst_r;
    llast_nxt   = llast_r;
    lrep_nxt    = lrep_r;
    status      = psevb_pkg::FS_NONE;
    unique case (op)
      psevb_pkg::OP_RESET: begin
        time_nxt    = '0;
        levels_nxt  = '0;
        err_nxt     = 1'b0;
        count_nxt   = '0;
        longest_nxt = '0;
        last_nxt    = '0;
        order_nxt   = 1'b1;
        lfirst_nxt  = '0;
        llast_nxt   = '0;
        lrep_nxt    = '0;
      end
      psevb_pkg::OP_SET, psevb_pkg::OP_CLEAR, psevb_pkg::OP_TOGGLE: begin
        if (!err_r) begin
          if (bad_ch) begin
            err_nxt = 1'b1;
          end else begin
            levels_nxt = new_lvl;
            err_nxt    = want_app && full;
          end
        end
      end
      psevb_pkg::OP_SET_MASK: begin
        if (!err_r) begin
          levels_nxt = cmd.new_mask;
          err_nxt    = want_app && full;
        end
      end
      psevb_pkg::OP_DELAY: begin
        if (!err_r) time_nxt = time_r + cmd.delay_ticks;
      end
      psevb_pkg::OP_ADC_TRIGGER: begin
        if (!err_r) err_nxt = full;
      end
      psevb_pkg::OP_LOOP_START: begin
        if (!err_r) lfirst_nxt = count_r;
      end
      psevb_pkg::OP_LOOP_END: begin
        if (!err_r) begin
          llast_nxt = count_r;
          lrep_nxt  = cmd.repeat_count;
        end
      end
      psevb_pkg::OP_FINALIZE: begin
        // closing event never touches the mask; a full table drops it quietly
        if (err_r) begin
          status = psevb_pkg::FS_ERROR;
        end else if ((cnt_after == '0) || !ord_after || loop_bad) begin
          status = psevb_pkg::FS_INVALID;
        end else begin
          status = psevb_pkg::FS_OK;
        end
      end
      default: status = psevb_pkg::FS_NONE;
    endcase
  end

  // Result fields
  assign idx_ext = EW'(count_r);
  assign lf_ext  = EW'(lfirst_nxt);
  assign ll_ext  = EW'(llast_nxt);

  always_comb begin
    res.event_valid       = app_ok;
    res.event_time        = app_ok ? time_r : 32'd0;
    res.event_mask        = app_ok ? app_mask : 8'h00;
    res.event_flags       = app_ok ? app_flags : 8'h00;
    res.event_index       = app_ok ? idx_ext[psevb_pkg::INDEX_W-1:0] : '0;
    res.error_flag        = err_nxt;
    res.final_status      = status;
    res.duration          = longest_nxt;
    res.loop_first_index  = lf_ext[psevb_pkg::LOOP_W-1:0];
    res.loop_last_index   = ll_ext[psevb_pkg::LOOP_W-1:0];
    res.loop_repeat_count = lrep_nxt;
  end

  // State update on each accepted command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r    <= '0;
      levels_r  <= '0;
      err_r     <= 1'b0;
      count_r   <= '0;
      longest_r <= '0;
      last_r    <= '0;
      order_r   <= 1'b1;
      lfirst_r  <= '0;
      llast_r   <= '0;
      lrep_r    <= '0;
    end else if (accept) begin
      time_r    <= time_nxt;
      levels_r  <= levels_nxt;
      err_r     <= err_nxt;
      count_r   <= count_nxt;
      longest_r <= longest_nxt;
      last_r    <= last_nxt;
      order_r   <= order_nxt;
      lfirst_r  <= lfirst_nxt;
      llast_r   <= llast_nxt;
      lrep_r    <= lrep_nxt;
    end
  end

endmodule

>>> src/pulse_sequence_event_builder.sv
// A result is registered at the same edge that accepts its command.
// Throughput: one command per cycle when not stalled; the state registers
// and the result register both load at the accepting edge, so back-to-back
// commands flow. The input stalls only while a finished result waits on
// the output. Reset (synchronous, rst_n low) clears all sequence state,
// as the reset command does, and empties the result register.
module pulse_sequence_event_builder #(
  parameter int unsigned CHANNELS   = 8,
  parameter int unsigned MAX_EVENTS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  psevb_cmd_if.sink    in_cmd,
  psevb_res_if.source  out_res
);

  logic            accept;
  logic            out_valid_r, out_valid_nxt;
  psevb_pkg::cmd_t cmd;
  psevb_pkg::res_t res;
  psevb_pkg::res_t res_r;

  // Input side takes an item whenever the result slot is free or draining
  assign in_cmd.ready = !out_valid_r || out_res.ready;
  assign accept       = in_cmd.valid && in_cmd.ready;

  assign cmd.opcode       = in_cmd.opcode;
  assign cmd.channel      = in_cmd.channel;
  assign cmd.new_mask     = in_cmd.new_mask;
  assign cmd.delay_ticks  = in_cmd.delay_ticks;
  assign cmd.repeat_count = in_cmd.repeat_count;

  psevb_core #(
    .CHANNELS   (CHANNELS),
    .MAX_EVENTS (MAX_EVENTS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .cmd    (cmd),
    .res    (res)
  );

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_res.valid             = out_valid_r;
  assign out_res.event_valid       = res_r.event_valid;
  assign out_res.event_time        = res_r.event_time;
  assign out_res.event_mask        = res_r.event_mask;
  assign out_res.event_flags       = res_r.event_flags;
  assign out_res.event_index       = res_r.event_index;
  assign out_res.error_flag        = res_r.error_flag;
  assign out_res.final_status      = res_r.final_status;
  assign out_res.duration          = res_r.duration;
  assign out_res.loop_first_index  = res_r.loop_first_index;
  assign out_res.loop_last_index   = res_r.loop_last_index;
  assign out_res.loop_repeat_count = res_r.loop_repeat_count;

endmodule

>>> src/psevb_checker.sv
// Port-level checks for the pulse sequence event builder, bound to the top.
// Depends on pulse_sequence_event_builder_macros.svh and psevb_pkg.
`include "pulse_sequence_event_builder_macros.svh"

module psevb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        event_valid,
  input logic [31:0] event_time,
  input logic [7:0]  event_mask,
  input logic [7:0]  event_flags,
  input logic [9:0]  event_index,
  input logic        error_flag,
  input logic [1:0]  final_status
);

  // a stalled result holds
  `PSEVB_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(event_time) && $stable(final_status), "result changed while stalled")

  // a draining output never blocks the input
  `PSEVB_ASSERT_NOW(a_flow, out_ready, in_ready, "input stalled while output drains")

  // no event means all event fields are zero
  `PSEVB_ASSERT_NOW(a_noev, out_valid && !event_valid, (event_time == 32'd0) && (event_mask == 8'h00) && (event_flags == 8'h00) && (event_index == 10'd0), "stale event fields")

  // a builder-error report comes with the sticky error and no event
  `PSEVB_ASSERT_NOW(a_err, out_valid && (final_status == psevb_pkg::FS_ERROR), error_flag && !event_valid, "error report inconsistent")

  // only adc triggers carry a flag, and only the adc bit
  `PSEVB_ASSERT_NOW(a_flags, out_valid && event_valid, (event_flags == 8'h00) || (event_flags == psevb_pkg::ADC_FLAG), "unexpected event flags")

endmodule

bind pulse_sequence_event_builder psevb_checker u_psevb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_cmd.ready),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .event_valid  (out_res.event_valid),
  .event_time   (out_res.event_time),
  .event_mask   (out_res.event_mask),
  .event_flags  (out_res.event_flags),
  .event_index  (out_res.event_index),
  .error_flag   (out_res.error_flag),
  .final_status (out_res.final_status)
);
